// ----- rtl/cat2_pkg.sv -----
// ----------------------------------------------------------------------------
// cat2_pkg: shared types and constants for the CORDIC atan2 block
// Widths, fixed-point constants, the arctangent step table and the
// command/status bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package cat2_pkg;

  // Field widths
  localparam int COORD_W = 64;
  localparam int ANGLE_W = 35;
  localparam int IDX_W   = 5;   // index into the 32-entry step table
  localparam int CNT_W   = 6;   // step counter, holds 0..32

  // pi in Q32.32
  localparam logic signed [ANGLE_W-1:0] PI_RAW = 35'sd13493037705;

  // Largest magnitude allowed after normalization: (2^63-1)/4
  localparam logic signed [COORD_W-1:0] SAFE_MAG = 64'sh1FFF_FFFF_FFFF_FFFF;

  // Command word from controller to datapath
  typedef struct packed {
    logic             load;   // capture a new coordinate pair
    logic             shift;  // normalize: both coordinates >>> 1
    logic             quad;   // quadrant fold and angle preset
    logic             step;   // one CORDIC vectoring step
    logic             emit;   // copy angle into the output register
    logic [IDX_W-1:0] idx;    // step number
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic need_shift;  // a coordinate is still too large
    logic y_zero;      // y has reached exactly zero
  } sts_t;

  // atan(2^-i) in Q32.32
  function automatic logic [31:0] step_angle(input logic [IDX_W-1:0] i);
    logic [31:0] a;
    unique case (i)
      5'd0:  a = 32'd3373259426;
      5'd1:  a = 32'd1991351318;
      5'd2:  a = 32'd1052175346;
      5'd3:  a = 32'd534100635;
      5'd4:  a = 32'd268086748;
      5'd5:  a = 32'd134174063;
      5'd6:  a = 32'd67103403;
      5'd7:  a = 32'd33553749;
      5'd8:  a = 32'd16777131;
      5'd9:  a = 32'd8388597;
      5'd10: a = 32'd4194303;
      5'd11: a = 32'd2097152;
      5'd12: a = 32'd1048576;
      5'd13: a = 32'd524288;
      5'd14: a = 32'd262144;
      5'd15: a = 32'd131072;
      5'd16: a = 32'd65536;
      5'd17: a = 32'd32768;
      5'd18: a = 32'd16384;
      5'd19: a = 32'd8192;
      5'd20: a = 32'd4096;
      5'd21: a = 32'd2048;
      5'd22: a = 32'd1024;
      5'd23: a = 32'd512;
      5'd24: a = 32'd256;
      5'd25: a = 32'd128;
      5'd26: a = 32'd64;
      5'd27: a = 32'd32;
      5'd28: a = 32'd16;
      5'd29: a = 32'd8;
      5'd30: a = 32'd4;
      5'd31: a = 32'd2;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/cat2_coord_if.sv -----
// ----------------------------------------------------------------------------
// cat2_coord_if: coordinate channel
// Valid/ready channel carrying one (y, x) word in signed Q32.32.
// ----------------------------------------------------------------------------
`default_nettype none

interface cat2_coord_if import cat2_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] y_value;
  logic signed [COORD_W-1:0] x_value;

  modport source (output valid, output y_value, output x_value, input ready);
  modport sink   (input valid, input y_value, input x_value, output ready);
endinterface

`default_nettype wire

// ----- rtl/cat2_angle_if.sv -----
// ----------------------------------------------------------------------------
// cat2_angle_if: angle channel
// Valid/ready channel carrying one angle word in signed Q32.32 radians.
// ----------------------------------------------------------------------------
`default_nettype none

interface cat2_angle_if import cat2_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] angle;

  modport source (output valid, output angle, input ready);
  modport sink   (input valid, input angle, output ready);
endinterface

`default_nettype wire

// ----- rtl/cordic_atan2_q32.sv -----
// ----------------------------------------------------------------------------
// cordic_atan2_q32: four-quadrant arctangent by CORDIC vectoring
// Top level: sequencer plus datapath behind two valid/ready channels.
// ----------------------------------------------------------------------------
// Takes a signed Q32.32 pair (y, x) and returns atan2(y, x) as a signed
// Q32.32 radian angle in a 35-bit word; a zero pair gives zero. One word is
// worked on at a time. After acceptance the block runs the normalizing right
// shifts (0 to 3), the quadrant fold, the vectoring steps of the single
// shared shift-add unit (up to ITERATIONS, fewer once y reaches zero) and
// the load of the output register; the next word is taken after that load.
// The result waits in the output register while the next word is already
// being taken and worked on; if that result is still waiting when the next
// word finishes its steps, the next word holds in the step loop until the
// output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module cordic_atan2_q32 import cat2_pkg::*; #(
  parameter int ITERATIONS = 32
) (
  input  logic         clk,
  input  logic         rst,
  cat2_coord_if.sink   coord,
  cat2_angle_if.source result
);

  cmd_t cmd;
  sts_t sts;

  cat2_ctrl #(
    .ITERATIONS (ITERATIONS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .coord_valid  (coord.valid),
    .coord_ready  (coord.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  cat2_dp u_dp (
    .clk   (clk),
    .cmd   (cmd),
    .y_in  (coord.y_value),
    .x_in  (coord.x_value),
    .sts   (sts),
    .angle (result.angle)
  );

endmodule

`default_nettype wire

// ----- rtl/cat2_dp.sv -----
// ----------------------------------------------------------------------------
// cat2_dp: CORDIC datapath
// Vector registers, one shared shift-add vectoring unit, the angle
// accumulator and the output angle register.
// ----------------------------------------------------------------------------
`default_nettype none

module cat2_dp import cat2_pkg::*; (
  input  logic                      clk,
  input  cmd_t                      cmd,
  input  logic signed [COORD_W-1:0] y_in,
  input  logic signed [COORD_W-1:0] x_in,
  output sts_t                      sts,
  output logic signed [ANGLE_W-1:0] angle
);

  logic signed [COORD_W-1:0] vx;
  logic signed [COORD_W-1:0] vy;
  logic signed [ANGLE_W-1:0] acc;
  logic signed [ANGLE_W-1:0] angle_q;

  logic signed [COORD_W-1:0] sx;
  logic signed [COORD_W-1:0] sy;
  logic signed [ANGLE_W-1:0] step_ang;
  logic                      x_big;
  logic                      y_big;

  // status: magnitude check and zero detect
  assign x_big = (vx > SAFE_MAG) || (vx < -SAFE_MAG);
  assign y_big = (vy > SAFE_MAG) || (vy < -SAFE_MAG);
  assign sts.need_shift = x_big || y_big;
  assign sts.y_zero     = (vy == '0);

  // shared barrel shifters and table angle
  assign sx       = vx >>> cmd.idx;
  assign sy       = vy >>> cmd.idx;
  assign step_ang = signed'({{(ANGLE_W-32){1'b0}}, step_angle(cmd.idx)});

  // vector and accumulator
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vx  <= x_in;
      vy  <= y_in;
      acc <= '0;
    end else if (cmd.shift) begin
      vx <= vx >>> 1;
      vy <= vy >>> 1;
    end else if (cmd.quad) begin
      if (vx[COORD_W-1]) begin
        vx  <= -vx;
        vy  <= -vy;
        acc <= vy[COORD_W-1] ? -PI_RAW : PI_RAW;
      end
    end else if (cmd.step) begin
      if (!vy[COORD_W-1]) begin
        vx  <= vx + sy;
        vy  <= vy - sx;
        acc <= acc + step_ang;
      end else begin
        vx  <= vx - sy;
        vy  <= vy + sx;
        acc <= acc - step_ang;
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      angle_q <= acc;
    end
  end

  assign angle = angle_q;

endmodule

`default_nettype wire

// ----- rtl/cat2_ctrl.sv -----
// ----------------------------------------------------------------------------
// cat2_ctrl: CORDIC sequencer
// Walks each word through normalization, quadrant fold and the vectoring
// steps, and owns the input ready and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module cat2_ctrl import cat2_pkg::*; #(
  parameter int ITERATIONS = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic coord_valid,
  output logic coord_ready,
  output logic result_valid,
  input  logic result_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_NORM = 2'd1;
  localparam logic [1:0] S_ITER = 2'd2;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             out_valid;
  logic             out_valid_next;
  logic             out_free;
  logic             finished;

  assign out_free = !out_valid || result_ready;
  assign finished = sts.y_zero || (cnt == CNT_W'(ITERATIONS));

  // next state and commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.idx    = cnt[IDX_W-1:0];
    unique case (state)
      S_IDLE: begin
        if (coord_valid) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = S_NORM;
        end
      end
      S_NORM: begin
        if (sts.need_shift) begin
          cmd.shift = 1'b1;
        end else begin
          cmd.quad   = 1'b1;
          state_next = S_ITER;
        end
      end
      S_ITER: begin
        if (finished) begin
          if (out_free) begin
            cmd.emit   = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          cmd.step = 1'b1;
          cnt_next = cnt + 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // output word holds until taken
  always_comb begin
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (result_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  assign coord_ready  = (state == S_IDLE);
  assign result_valid = out_valid;

endmodule

`default_nettype wire

// ----- rtl/cat2_check.sv -----
// ----------------------------------------------------------------------------
// cat2_check: port-level checks for the CORDIC atan2 block
// Watches the handshakes of the top level and is bound to it below.
// ----------------------------------------------------------------------------
`default_nettype none

module cat2_check import cat2_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      coord_valid,
  input logic                      coord_ready,
  input logic                      result_valid,
  input logic                      result_ready,
  input logic signed [ANGLE_W-1:0] result_angle
);

  // no word is offered right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_angle))
    else $error("stalled angle word changed or dropped");

  // normalization and quadrant fold keep the input closed
  a_busy: assert property (@(posedge clk) disable iff (rst)
    coord_valid && coord_ready |=> !coord_ready ##1 !coord_ready)
    else $error("input reopened before the quadrant fold");

  // a new result only comes out of the step loop, when the input was closed
  a_from_loop: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> !$past(coord_ready))
    else $error("result appeared while the block was idle");

endmodule

bind cordic_atan2_q32 cat2_check u_cat2_check (
  .clk          (clk),
  .rst          (rst),
  .coord_valid  (coord.valid),
  .coord_ready  (coord.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .result_angle (result.angle)
);

`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for cordic_atan2_q32
// Drives (y, x) coordinate words through the valid/ready input channel and
// checks every angle word against a bit-exact CORDIC vectoring predictor,
// or the angle column for typed rows. A directed table covers zero pairs,
// extremes and the normalization edge; random words follow, with bursty
// input, a stalling output, one long output hold-off and one drain pause.
// ----------------------------------------------------------------------------

module tb;
  import cat2_pkg::*;

  localparam int          STEPS       = 32;
  localparam int          RANDOM_WORDS = 800;
  localparam int          LONG_HOLD   = 400;
  localparam int          QUIET_LIMIT = 4000;
  localparam int          TAIL_CYCLES = 60;

  localparam logic [63:0] C_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] C_MIN      = 64'h8000_0000_0000_0000;
  localparam logic [63:0] C_NEG1     = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NORM_LIMIT = 64'h1FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] PI_Q32     = 64'd13493037705;
  localparam logic [34:0] PI_ANGLE   = 35'd13493037705;

  // atan(2^-i) in Q32.32
  localparam logic [31:0] ATAN_STEP [STEPS] = '{
    32'd3373259426, 32'd1991351318, 32'd1052175346, 32'd534100635,
    32'd268086748,  32'd134174063,  32'd67103403,   32'd33553749,
    32'd16777131,   32'd8388597,    32'd4194303,    32'd2097152,
    32'd1048576,    32'd524288,     32'd262144,     32'd131072,
    32'd65536,      32'd32768,      32'd16384,      32'd8192,
    32'd4096,       32'd2048,       32'd1024,       32'd512,
    32'd256,        32'd128,        32'd64,         32'd32,
    32'd16,         32'd8,          32'd4,          32'd2
  };

  // directed row: typed = 1 means the angle column holds the answer
  typedef struct packed {
    logic [63:0] y;
    logic [63:0] x;
    logic        typed;
    logic [34:0] angle;
  } dir_row_t;

  localparam int N_DIRECTED = 24;
  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    '{64'd0,          64'd0,     1'b1, 35'd0},      // zero pair
    '{64'd0,          64'd1,     1'b1, 35'd0},      // on positive x axis
    '{64'd0,          C_MAX,     1'b1, 35'd0},
    '{64'd0,          C_NEG1,    1'b1, PI_ANGLE},   // negative x, zero y
    '{64'd0,          C_MIN,     1'b1, PI_ANGLE},
    '{64'd1,          64'd0,     1'b0, 35'd0},
    '{C_NEG1,         64'd0,     1'b0, 35'd0},
    '{C_MAX,          64'd0,     1'b0, 35'd0},
    '{C_MIN,          64'd0,     1'b0, 35'd0},
    '{C_MAX,          C_MAX,     1'b0, 35'd0},
    '{C_MIN,          C_MIN,     1'b0, 35'd0},
    '{C_MAX,          C_MIN,     1'b0, 35'd0},
    '{C_MIN,          C_MAX,     1'b0, 35'd0},
    '{C_NEG1,         C_NEG1,    1'b0, 35'd0},
    '{64'd1,          C_NEG1,    1'b0, 35'd0},
    '{C_NEG1,         64'd1,     1'b0, 35'd0},
    '{C_NEG1,         C_MIN,     1'b0, 35'd0},
    '{C_MIN,          C_NEG1,    1'b0, 35'd0},
    '{NORM_LIMIT,     NORM_LIMIT, 1'b0, 35'd0},     // largest unshifted
    '{NORM_LIMIT + 1, 64'd1,     1'b0, 35'd0},      // one shift needed
    '{64'hE000_0000_0000_0000, -64'sd7, 1'b0, 35'd0},
    '{64'h1_0000_0000, 64'h1_0000_0000, 1'b0, 35'd0},
    '{-64'sh1_0000_0000, -64'sh3_0000_0000, 1'b0, 35'd0},
    '{64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 35'd0}
  };

  logic clk = 1'b0;
  logic rst;

  cat2_coord_if coord ();
  cat2_angle_if result ();

  cordic_atan2_q32 dut (
    .clk    (clk),
    .rst    (rst),
    .coord  (coord),
    .result (result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic [34:0] pending_angles [$];
  logic [34:0] want_angle;
  int          mismatches = 0;
  int          quiet_cycles = 0;
  int          burst_left = 0;
  bit          hold_request = 1'b0;

  // Bit-exact angle of one coordinate pair
  function automatic logic [34:0] cordic_angle(input logic [63:0] y, input logic [63:0] x);
    logic [63:0] vy, vx, ox, my, mx, sy, sx, acc;
    vy  = y;
    vx  = x;
    acc = '0;
    if (vx == 64'd0 && vy == 64'd0) return '0;
    // normalize both coordinates together
    for (int k = 0; k < 64; k++) begin
      mx = vx[63] ? (~vx + 64'd1) : vx;
      my = vy[63] ? (~vy + 64'd1) : vy;
      if (mx <= NORM_LIMIT && my <= NORM_LIMIT) break;
      vx = $signed(vx) >>> 1;
      vy = $signed(vy) >>> 1;
    end
    // left half plane: preset +-pi and turn the vector around
    if (vx[63]) begin
      acc = vy[63] ? (64'd0 - PI_Q32) : PI_Q32;
      vx  = 64'd0 - vx;
      vy  = 64'd0 - vy;
    end
    // vectoring steps, stop once y is exactly zero
    for (int i = 0; i < STEPS; i++) begin
      if (vy == 64'd0) break;
      ox = vx;
      sy = $signed(vy) >>> i;
      sx = $signed(ox) >>> i;
      if (!vy[63]) begin
        vx  = vx + sy;
        vy  = vy - sx;
        acc = acc + {32'd0, ATAN_STEP[i]};
      end else begin
        vx  = vx - sy;
        vy  = vy + sx;
        acc = acc - {32'd0, ATAN_STEP[i]};
      end
    end
    return acc[34:0];
  endfunction

  // Random coordinate from a mix of shapes
  function automatic logic [63:0] pick_coord();
    logic [63:0] v;
    int          s;
    case ($urandom_range(0, 9))
      0, 1, 2, 9: v = {$urandom, $urandom};
      3, 4: begin
        v = {$urandom, $urandom};
        v = $signed(v) >>> $urandom_range(20, 62);
      end
      5: begin
        s = $urandom_range(0, 64) - 32;
        v = {{32{s[31]}}, s};
      end
      6: begin
        // around the normalization threshold
        v = NORM_LIMIT + $urandom_range(0, 6) - 3;
        if ($urandom_range(0, 1) == 1) v = 64'd0 - v;
      end
      7: begin
        case ($urandom_range(0, 4))
          0: v = C_MAX;
          1: v = C_MIN;
          2: v = C_NEG1;
          3: v = 64'd1;
          default: v = 64'd0;
        endcase
      end
      default: v = 64'd0;
    endcase
    return v;
  endfunction

  // Offer one word in bursts; record its expected angle on acceptance
  task automatic send_pair(input logic [63:0] y, input logic [63:0] x,
                           input logic typed, input logic [34:0] typed_angle);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      gap        = $urandom_range(1, 25);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    if (gap > 0) begin
      coord.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    coord.valid   <= 1'b1;
    coord.y_value <= y;
    coord.x_value <= x;
    do @(posedge clk); while (!coord.ready);
    pending_angles.push_back(typed ? typed_angle : cordic_angle(y, x));
  endtask

  // Stimulus
  initial begin
    logic [63:0] ry, rx;
    coord.valid   <= 1'b0;
    coord.y_value <= '0;
    coord.x_value <= '0;
    rst           <= 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[r])
      send_pair(DIRECTED[r].y, DIRECTED[r].x, DIRECTED[r].typed, DIRECTED[r].angle);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == 300) hold_request = 1'b1;
      if (n == 500) begin
        // let the block drain completely
        coord.valid <= 1'b0;
        do @(posedge clk); while (pending_angles.size() != 0);
      end
      ry = pick_coord();
      rx = pick_coord();
      send_pair(ry, rx, 1'b0, 35'd0);
    end
    coord.valid <= 1'b0;

    while (pending_angles.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // Output ready: random modes per stretch, plus one long hold-off
  initial begin
    int mode, span, phase;
    phase = 0;
    result.ready <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 80);
      repeat (span) begin
        @(posedge clk);
        phase++;
        if (hold_request) begin
          hold_request = 1'b0;
          result.ready <= 1'b0;
          for (int h = 0; h < LONG_HOLD; h++) @(posedge clk);
        end else begin
          case (mode)
            0: result.ready <= 1'b1;
            1: result.ready <= ($urandom_range(0, 1) == 1);
            2: result.ready <= ($urandom_range(0, 3) == 0);
            default: result.ready <= ((phase % 5) >= 2);
          endcase
        end
      end
    end
  end

  // Angle word check
  always @(posedge clk) begin
    if (!rst && result.valid && result.ready) begin
      if (pending_angles.size() == 0) begin
        mismatches++;
        $display("%0t: angle word %0d with no input pending", $time, result.angle);
      end else begin
        want_angle = pending_angles.pop_front();
        if (result.angle !== want_angle) begin
          mismatches++;
          $display("%0t: angle mismatch, expected %0d, got %0d", $time,
                   $signed(want_angle), result.angle);
        end
      end
    end
  end

  // Watchdog: cycles with no word moving on either channel
  always @(posedge clk) begin
    if (rst || (coord.valid && coord.ready) || (result.valid && result.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
